// ===== hw/rtl/lgr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgr_pkg
// Shared types and constants for the Life generation row unit.
// ----------------------------------------------------------------------------
package lgr_pkg;

  localparam int ROW_WIDTH   = 64;
  localparam int INDEX_WIDTH = 6;
  localparam int HEIGHT_WIDTH = 7;
  localparam int COUNT_WIDTH = 4;

  localparam int MAX_RESULTS = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int PUSH_WIDTH  = 2;
  localparam int FILL_WIDTH  = 3;

  localparam int APB_ADDR_WIDTH = 3;
  localparam int APB_DATA_WIDTH = 32;

  localparam logic [COUNT_WIDTH-1:0] BIRTH_COUNT   = 4'd3;
  localparam logic [COUNT_WIDTH-1:0] SURVIVE_COUNT = 4'd2;

  localparam logic [HEIGHT_WIDTH-1:0] MIN_HEIGHT   = 7'd3;
  localparam logic [HEIGHT_WIDTH-1:0] RESET_HEIGHT = 7'd60;

  typedef enum logic {
    REG_ROWS_IN_USE = 1'b0,
    REG_NONE        = 1'b1
  } reg_sel_t;

  typedef struct packed {
    logic [INDEX_WIDTH-1:0] row_index;
    logic [ROW_WIDTH-1:0]   next_cells;
    logic                   frame_done;
  } result_t;

  typedef struct packed {
    logic [PUSH_WIDTH-1:0] push_count;
    logic                  room;
  } queue_ctrl_t;

endpackage

// ===== hw/rtl/lgr_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgr_stream_if
// Valid/ready channels for input rows and result rows.
// ----------------------------------------------------------------------------
interface lgr_row_if;
  logic        valid;
  logic        ready;
  logic [63:0] row_cells;

  modport source (output valid, output row_cells, input ready);
  modport sink (input valid, input row_cells, output ready);
endinterface

interface lgr_result_if;
  logic        valid;
  logic        ready;
  logic [5:0]  row_index;
  logic [63:0] next_cells;
  logic        frame_done;

  modport source (output valid, output row_index, output next_cells, output frame_done,
                  input ready);
  modport sink (input valid, input row_index, input next_cells, input frame_done,
                output ready);
endinterface

// ===== hw/rtl/lgr_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgr_cell
// One cell lane: counts eight neighbours and applies rule B3/S23.
// ----------------------------------------------------------------------------
module lgr_cell
  import lgr_pkg::*;
(
  input  logic [2:0] above,
  input  logic [2:0] mid,
  input  logic [2:0] below,
  output logic       next_state
);

  logic [COUNT_WIDTH-1:0] neighbours;

  assign neighbours = COUNT_WIDTH'(above[0]) + COUNT_WIDTH'(above[1])
                    + COUNT_WIDTH'(above[2]) + COUNT_WIDTH'(mid[0])
                    + COUNT_WIDTH'(mid[2]) + COUNT_WIDTH'(below[0])
                    + COUNT_WIDTH'(below[1]) + COUNT_WIDTH'(below[2]);

  assign next_state = (neighbours == BIRTH_COUNT)
                    || (mid[1] && (neighbours == SURVIVE_COUNT));

endmodule

// ===== hw/rtl/lgr_row_evolve.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgr_row_evolve
// One cell lane per column, with column wrap, merged into the next row word.
// ----------------------------------------------------------------------------
module lgr_row_evolve
  import lgr_pkg::*;
#(
  parameter int ROW_CELLS = 64
) (
  input  logic [ROW_WIDTH-1:0] above,
  input  logic [ROW_WIDTH-1:0] mid,
  input  logic [ROW_WIDTH-1:0] below,
  output logic [ROW_WIDTH-1:0] next_row
);

  genvar x;
  generate
    for (x = 0; x < ROW_CELLS; x++) begin : g_lane
      localparam int W = (x == 0) ? ROW_CELLS - 1 : x - 1;
      localparam int E = (x == ROW_CELLS - 1) ? 0 : x + 1;
      lgr_cell u_cell (
        .above      ({above[E], above[x], above[W]}),
        .mid        ({mid[E], mid[x], mid[W]}),
        .below      ({below[E], below[x], below[W]}),
        .next_state (next_row[x])
      );
    end
    for (x = ROW_CELLS; x < ROW_WIDTH; x++) begin : g_unused
      assign next_row[x] = 1'b0;
    end
  endgenerate

endmodule

// ===== hw/rtl/lgr_result_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgr_result_queue
// Shifting result queue that takes up to three results at once and
// delivers one beat per cycle from its head while results.ready is high.
// ----------------------------------------------------------------------------
module lgr_result_queue
  import lgr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  queue_ctrl_t         ctrl_in,
  output logic                room,
  input  result_t             push_data [MAX_RESULTS],
  lgr_result_if.source        results
);

  result_t               entry      [QUEUE_DEPTH];
  result_t               entry_next [QUEUE_DEPTH];
  logic [FILL_WIDTH-1:0] count;
  logic [FILL_WIDTH-1:0] count_next;
  logic [FILL_WIDTH-1:0] base;
  logic [FILL_WIDTH-1:0] slot;
  logic                  pop;

  assign pop  = (count != '0) && results.ready;
  assign base = count - FILL_WIDTH'(pop);
  assign room = count <= FILL_WIDTH'(QUEUE_DEPTH - MAX_RESULTS);
  assign count_next = base + FILL_WIDTH'(ctrl_in.push_count);

  always_comb begin
    entry_next = entry;
    slot = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      slot = FILL_WIDTH'(i) - base;
      if (FILL_WIDTH'(i) < base) begin
        if (pop) begin
          entry_next[i] = entry[(i == QUEUE_DEPTH - 1) ? i : i + 1];
        end
      end else if (slot < FILL_WIDTH'(ctrl_in.push_count)) begin
        entry_next[i] = push_data[slot[PUSH_WIDTH-1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
    entry <= entry_next;
  end

  assign results.valid      = count != '0;
  assign results.row_index  = entry[0].row_index;
  assign results.next_cells = entry[0].next_cells;
  assign results.frame_done = entry[0].frame_done;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= FILL_WIDTH'(QUEUE_DEPTH))
    else $error("result queue overfilled");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    (ctrl_in.push_count != '0) |-> ctrl_in.room)
    else $error("results pushed without room");

  a_fill_tracks: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> count == $past(count) - FILL_WIDTH'($past(pop))
                      + FILL_WIDTH'($past(ctrl_in.push_count)))
    else $error("queue fill count drifted");

endmodule

// ===== hw/rtl/life_generation_rows_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_generation_rows_unit
// Advances a toroidal Life grid one generation (B3/S23), one row per beat.
//
//   channel   direction  handshake        payload
//   rows      in         valid/ready      row_cells[63:0]
//   results   out        valid/ready      row_index[5:0], next_cells[63:0],
//                                          frame_done
//   apb       in         psel/penable     rows_in_use at byte address 0
//
// A row is taken only while the output queue has room, and its results enter
// that queue at the clock edge that takes the row; the queue delivers one result
// beat per cycle while results.ready is high. Rows stream at one per cycle while
// results drain, until the last row of a frame, whose three results stall the input.
// Reset is synchronous and clears the row history and frame position.
// Input stalls whenever the output queue cannot hold three more results.
// ----------------------------------------------------------------------------
module life_generation_rows_unit
  import lgr_pkg::*;
#(
  parameter int ROW_CELLS = 64,
  parameter int MAX_ROWS  = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  lgr_row_if.sink                   rows,
  lgr_result_if.source              results,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_ADDR_WIDTH-1:0] paddr,
  input  logic [APB_DATA_WIDTH-1:0] pwdata,
  output logic [APB_DATA_WIDTH-1:0] prdata,
  output logic                      pready
);

  localparam logic [ROW_WIDTH-1:0] COL_MASK = {ROW_WIDTH{1'b1}} >> (ROW_WIDTH - ROW_CELLS);
  localparam logic [HEIGHT_WIDTH-1:0] MAX_HEIGHT = HEIGHT_WIDTH'(MAX_ROWS);

  logic [HEIGHT_WIDTH-1:0] rows_in_use;
  logic [ROW_WIDTH-1:0]    first_row;
  logic [ROW_WIDTH-1:0]    second_row;
  logic [ROW_WIDTH-1:0]    older_row;
  logic [ROW_WIDTH-1:0]    newer_row;
  logic [INDEX_WIDTH-1:0]  rows_seen;

  logic [ROW_WIDTH-1:0]    row;
  logic [HEIGHT_WIDTH-1:0] height;
  logic                    accept;
  logic                    last_row;
  logic                    emits;
  logic                    room;
  reg_sel_t                reg_sel;
  queue_ctrl_t             queue_ctrl;
  result_t                 push_data [MAX_RESULTS];
  logic [ROW_WIDTH-1:0]    mid_next;
  logic [ROW_WIDTH-1:0]    last_next;
  logic [ROW_WIDTH-1:0]    top_next;

  assign pready  = 1'b1;
  assign reg_sel = reg_sel_t'(paddr[APB_ADDR_WIDTH-1]);
  assign prdata  = (reg_sel == REG_ROWS_IN_USE)
                 ? {{(APB_DATA_WIDTH - HEIGHT_WIDTH){1'b0}}, rows_in_use} : '0;

  assign row = rows.row_cells & COL_MASK;

  always_comb begin
    if (rows_in_use < MIN_HEIGHT) begin
      height = MIN_HEIGHT;
    end else if (rows_in_use > MAX_HEIGHT) begin
      height = MAX_HEIGHT;
    end else begin
      height = rows_in_use;
    end
  end

  assign emits    = rows_seen >= INDEX_WIDTH'(2);
  assign last_row = emits && ({1'b0, rows_seen} >= height - HEIGHT_WIDTH'(1));

  assign rows.ready = room;
  assign accept     = rows.valid && room;

  always_comb begin
    queue_ctrl.room = room;
    if (!accept || !emits) begin
      queue_ctrl.push_count = '0;
    end else if (last_row) begin
      queue_ctrl.push_count = PUSH_WIDTH'(MAX_RESULTS);
    end else begin
      queue_ctrl.push_count = PUSH_WIDTH'(1);
    end
  end

  lgr_row_evolve #(.ROW_CELLS(ROW_CELLS)) u_evolve_mid (
    .above (older_row), .mid (newer_row), .below (row), .next_row (mid_next)
  );

  lgr_row_evolve #(.ROW_CELLS(ROW_CELLS)) u_evolve_last (
    .above (newer_row), .mid (row), .below (first_row), .next_row (last_next)
  );

  lgr_row_evolve #(.ROW_CELLS(ROW_CELLS)) u_evolve_top (
    .above (row), .mid (first_row), .below (second_row), .next_row (top_next)
  );

  assign push_data[0] = '{row_index: rows_seen - INDEX_WIDTH'(1),
                          next_cells: mid_next, frame_done: 1'b0};
  assign push_data[1] = '{row_index: rows_seen, next_cells: last_next, frame_done: 1'b0};
  assign push_data[2] = '{row_index: '0, next_cells: top_next, frame_done: 1'b1};

  lgr_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .ctrl_in   (queue_ctrl),
    .room      (room),
    .push_data (push_data),
    .results   (results)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= RESET_HEIGHT;
      first_row   <= '0;
      second_row  <= '0;
      older_row   <= '0;
      newer_row   <= '0;
      rows_seen   <= '0;
    end else begin
      if (psel && penable && pwrite && reg_sel == REG_ROWS_IN_USE) begin
        rows_in_use <= pwdata[HEIGHT_WIDTH-1:0];
      end
      if (accept) begin
        if (rows_seen == INDEX_WIDTH'(0)) begin
          first_row <= row;
        end
        if (rows_seen == INDEX_WIDTH'(1)) begin
          second_row <= row;
        end
        older_row <= newer_row;
        newer_row <= row;
        rows_seen <= last_row ? '0 : rows_seen + INDEX_WIDTH'(1);
      end
    end
  end

  a_frame_wraps: assert property (@(posedge clk) disable iff (rst)
    (accept && last_row) |=> rows_seen == '0)
    else $error("frame position did not wrap after the last row");

  a_row_advances: assert property (@(posedge clk) disable iff (rst)
    (accept && !last_row) |=> rows_seen == $past(rows_seen) + INDEX_WIDTH'(1))
    else $error("frame position did not advance");

  a_done_on_row_zero: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.frame_done) |-> results.row_index == '0)
    else $error("frame end flagged on a row other than row zero");

endmodule
